FILE: src/assert_macros.svh
// Assertion macros shared by the sparse polynomial adder RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define SPA_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/spa_pkg.sv
// Package for the sparse polynomial adder: field widths, op codes,
// controller states and the command/status structs. No dependencies.
package spa_pkg;

   localparam int MAX_TERMS_DEF = 32;
   localparam int OP_W          = 2;
   localparam int COEF_W        = 16;
   localparam int EXP_W         = 16;
   localparam int COEF_OUT_W    = 17;

   localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
   localparam logic [OP_W-1:0] OP_ADD         = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } spa_state_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic [EXP_W-1:0]         exp;
   } spa_term_type;

   typedef struct packed {
      logic load_first;
      logic load_second;
      logic emit;
   } spa_cmd_type;

   typedef struct packed {
      logic out_free;
      logic term_last;
   } spa_sts_type;

endpackage

FILE: src/spa_ctrl.sv
// Controller for the sparse polynomial adder: decodes input beats and
// sequences the merge. Depends on spa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spa_ctrl
   import spa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [OP_W-1:0]   req_op,
   output logic              req_stall,
   input  spa_sts_type       sts,
   output spa_cmd_type       cmd
);

   spa_state_type state_ff, state_in;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_stall       = 1'b1;
      cmd.load_first  = 1'b0;
      cmd.load_second = 1'b0;
      cmd.emit        = 1'b0;
      accept          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            accept          = req_valid;
            cmd.load_first  = accept && (req_op == OP_LOAD_FIRST);
            cmd.load_second = accept && (req_op == OP_LOAD_SECOND);
            // unused op code falls through: drop the beat
            if (accept && (req_op == OP_ADD)) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            // one result term per cycle whenever the output register frees up
            cmd.emit = sts.out_free;
            if (sts.out_free && sts.term_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SPA_ASSERT_NEXT(a_last_returns_idle, clock, reset, cmd.emit && sts.term_last, state_ff == ST_IDLE, "merge did not end after the last term")
   `SPA_ASSERT_ALWAYS(a_no_load_in_merge, clock, reset, !(state_ff == ST_MERGE) || !(cmd.load_first || cmd.load_second), "load issued during merge")

endmodule

FILE: src/spa_dp.sv
// Datapath for the sparse polynomial adder: term memories, counts, merge
// pointers and the result register. Depends on spa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spa_dp
   import spa_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COEF_W-1:0]     req_coef_in,
   input  logic [EXP_W-1:0]             req_exp_in,
   input  spa_cmd_type                  cmd,
   output spa_sts_type                  sts,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COEF_OUT_W-1:0] rsp_coef_out,
   output logic [EXP_W-1:0]             rsp_exp_out,
   output logic                         rsp_last,
   output logic                         rsp_empty_res,
   output logic                         rsp_overflow
);

   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

   spa_term_type mem_a [MAX_TERMS];
   spa_term_type mem_b [MAX_TERMS];
   spa_term_type rd_a_ff, rd_b_ff;
   spa_term_type wr_term;

   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0] p_ff, p_in, q_ff, q_in, p_nxt, q_nxt;
   logic             dropped_ff, dropped_in;

   logic                         out_valid_ff, out_valid_in;
   logic signed [COEF_OUT_W-1:0] coef_ff, coef_in;
   logic [EXP_W-1:0]             exp_ff, exp_in;
   logic                         last_ff, empty_ff, ovf_ff;

   logic a_v, b_v, eq, take_a, adv_a, adv_b, empty, term_last, finish;

   assign wr_term.coef = req_coef_in;
   assign wr_term.exp  = req_exp_in;

   // merge decision on the terms at the current pointers
   always_comb begin
      a_v       = p_ff < cnt_a_ff;
      b_v       = q_ff < cnt_b_ff;
      empty     = (cnt_a_ff == '0) && (cnt_b_ff == '0);
      eq        = a_v && b_v && (rd_a_ff.exp == rd_b_ff.exp);
      take_a    = !b_v || (a_v && (rd_a_ff.exp > rd_b_ff.exp));
      adv_a     = eq || take_a;
      adv_b     = !take_a;
      p_nxt     = p_ff + CNT_W'(adv_a);
      q_nxt     = q_ff + CNT_W'(adv_b);
      term_last = empty || ((p_nxt >= cnt_a_ff) && (q_nxt >= cnt_b_ff));
      finish    = cmd.emit && term_last;
   end

   always_comb begin
      priority if (empty) begin
         coef_in = '0;
         exp_in  = '0;
      end else if (eq) begin
         coef_in = COEF_OUT_W'(rd_a_ff.coef) + COEF_OUT_W'(rd_b_ff.coef);
         exp_in  = rd_a_ff.exp;
      end else if (take_a) begin
         coef_in = COEF_OUT_W'(rd_a_ff.coef);
         exp_in  = rd_a_ff.exp;
      end else begin
         coef_in = COEF_OUT_W'(rd_b_ff.coef);
         exp_in  = rd_b_ff.exp;
      end
   end

   always_comb begin
      p_in       = p_ff;
      q_in       = q_ff;
      cnt_a_in   = cnt_a_ff;
      cnt_b_in   = cnt_b_ff;
      dropped_in = dropped_ff;
      if (finish) begin
         // clear both lists and the sticky flag once the add is done
         p_in       = '0;
         q_in       = '0;
         cnt_a_in   = '0;
         cnt_b_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.emit) begin
         p_in = p_nxt;
         q_in = q_nxt;
      end
      if (cmd.load_first) begin
         if (cnt_a_ff < MAX_CNT) cnt_a_in = cnt_a_ff + CNT_W'(1);
         else                    dropped_in = 1'b1;
      end
      if (cmd.load_second) begin
         if (cnt_b_ff < MAX_CNT) cnt_b_in = cnt_b_ff + CNT_W'(1);
         else                    dropped_in = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.emit) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         p_ff         <= '0;
         q_ff         <= '0;
         dropped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         p_ff         <= p_in;
         q_ff         <= q_in;
         dropped_ff   <= dropped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // term memories: write at the fill count, read at the next pointer
   always_ff @(posedge clock) begin
      if (cmd.load_first && (cnt_a_ff < MAX_CNT)) mem_a[cnt_a_ff[IDX_W-1:0]] <= wr_term;
      if (cmd.load_second && (cnt_b_ff < MAX_CNT)) mem_b[cnt_b_ff[IDX_W-1:0]] <= wr_term;
      if (p_in < MAX_CNT) rd_a_ff <= mem_a[p_in[IDX_W-1:0]];
      if (q_in < MAX_CNT) rd_b_ff <= mem_b[q_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         coef_ff  <= coef_in;
         exp_ff   <= exp_in;
         last_ff  <= term_last;
         empty_ff <= empty;
         ovf_ff   <= dropped_ff;
      end
   end

   assign sts.out_free  = !out_valid_ff || !rsp_stall;
   assign sts.term_last = term_last;

   assign rsp_valid     = out_valid_ff;
   assign rsp_coef_out  = coef_ff;
   assign rsp_exp_out   = exp_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_overflow  = ovf_ff;

   `SPA_ASSERT_ALWAYS(a_cnt_in_range, clock, reset, (cnt_a_ff <= MAX_CNT) && (cnt_b_ff <= MAX_CNT), "term count beyond capacity")
   `SPA_ASSERT_ALWAYS(a_ptr_in_range, clock, reset, (p_ff <= cnt_a_ff) && (q_ff <= cnt_b_ff), "merge pointer beyond its list")

endmodule

FILE: src/sparse_polynomial_adder_top.sv
// Sparse polynomial adder: two term lists (coefficient, exponent) filled by
// load beats, merged into result beats by an add beat in descending exponent
// order, equal exponents summed. Request beats arrive on req_* with
// req_valid/req_stall; results leave on rsp_* with rsp_valid/rsp_stall.
// req_op selects load into the first list, load into the second, or add.
// A load is accepted while idle and yields no result; a load into a full
// list is dropped and sets the overflow flag shown on the next add.
// An add holds req_stall high while it runs and emits one result beat per
// cycle, the first after the state and result registers; np + nq beats at
// most (one with rsp_empty_res for two empty lists), the last has rsp_last.
// The pace is set by the single read port of each term memory: one term
// of each list is looked at per cycle. The result register frees the merge
// as soon as its beat is taken; while rsp_stall is high the merge holds.
// After the final beat both lists and the overflow flag are cleared.
// Reset (synchronous, active high) empties both lists and clears the flag;
// memory contents are not cleared and need no clearing pass.
// Depends on spa_pkg, spa_ctrl and spa_dp.
module sparse_polynomial_adder_top
   import spa_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [OP_W-1:0]              req_op,
   input  logic signed [COEF_W-1:0]     req_coef_in,
   input  logic [EXP_W-1:0]             req_exp_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COEF_OUT_W-1:0] rsp_coef_out,
   output logic [EXP_W-1:0]             rsp_exp_out,
   output logic                         rsp_last,
   output logic                         rsp_empty_res,
   output logic                         rsp_overflow
);

   spa_cmd_type cmd;
   spa_sts_type sts;

   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   spa_dp #(
      .MAX_TERMS (MAX_TERMS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_coef_in   (req_coef_in),
      .req_exp_in    (req_exp_in),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_coef_out  (rsp_coef_out),
      .rsp_exp_out   (rsp_exp_out),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res),
      .rsp_overflow  (rsp_overflow)
   );

endmodule
